### design/iee_pkg.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Character codes, pending-operator codes and the request/status bundles of
// the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package iee_pkg;

   localparam int VALUE_WIDTH = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_MUL  = 2'd1,
      PEND_DIV  = 2'd2
   } pend_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } mdu_req_type;

   typedef struct packed {
      logic done;
      logic dz;
   } mdu_sts_type;

endpackage

### design/iee_muldiv.sv
// ----------------------------------------------------------------------------
// Iterative multiply/divide unit
// Shift-add multiply (low half kept) and restoring signed divide truncating
// toward zero, one bit per cycle through one shared adder.
// ----------------------------------------------------------------------------
module iee_muldiv #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iee_pkg::mdu_req_type    req,
   input  logic [DATA_WIDTH-1:0]   opa,
   input  logic [DATA_WIDTH-1:0]   opb,
   output iee_pkg::mdu_sts_type    sts,
   output logic [DATA_WIDTH-1:0]   result
);

   localparam int CW = $clog2(DATA_WIDTH);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_RUN  = 3'b010,
      U_FIX  = 3'b100
   } ustate_type;

   ustate_type            state_ff, state_in;
   iee_pkg::op_type       op_ff, op_in;
   logic                  neg_ff, neg_in;
   logic                  dz_ff, dz_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;

   logic [DATA_WIDTH-1:0] mag_a, mag_b;
   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH+1:0] add_x, add_y, sum;
   logic                  add_c, ge;

   assign mag_a     = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
   assign mag_b     = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;
   assign rem_shift = {rem_ff[DATA_WIDTH-1:0], opa_ff[DATA_WIDTH-1]};

   always_comb begin
      if (op_ff == iee_pkg::OP_DIV) begin
         add_x = {1'b0, rem_shift};
         add_y = ~{2'b00, opb_ff};
         add_c = 1'b1;
      end else begin
         add_x = {2'b00, rem_ff[DATA_WIDTH-1:0]};
         add_y = {2'b00, opa_ff};
         add_c = 1'b0;
      end
   end

   assign sum = add_x + add_y + {{(DATA_WIDTH+1){1'b0}}, add_c};
   assign ge  = ~sum[DATA_WIDTH+1];

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      dz_in     = dz_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      result_in = result_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               op_in  = req.op;
               dz_in  = 1'b0;
               rem_in = '0;
               cnt_in = CW'(DATA_WIDTH - 1);
               if (req.op == iee_pkg::OP_DIV) begin
                  opa_in = mag_a;
                  opb_in = mag_b;
                  neg_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                  if (opb == '0) begin
                     dz_in    = 1'b1;
                     opa_in   = '0;
                     neg_in   = 1'b0;
                     state_in = U_FIX;
                  end else begin
                     state_in = U_RUN;
                  end
               end else begin
                  opa_in   = opa;
                  opb_in   = opb;
                  neg_in   = 1'b0;
                  state_in = U_RUN;
               end
            end
         end
         U_RUN: begin
            if (op_ff == iee_pkg::OP_DIV) begin
               rem_in = ge ? sum[DATA_WIDTH:0] : rem_shift;
               opa_in = {opa_ff[DATA_WIDTH-2:0], ge};
            end else begin
               if (opb_ff[0]) begin
                  rem_in = {1'b0, sum[DATA_WIDTH-1:0]};
               end
               opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[DATA_WIDTH-1:1]};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = U_FIX;
            end
         end
         U_FIX: begin
            done_in = 1'b1;
            if (op_ff == iee_pkg::OP_DIV) begin
               result_in = neg_ff ? (~opa_ff + 1'b1) : opa_ff;
            end else begin
               result_in = rem_ff[DATA_WIDTH-1:0];
            end
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      dz_ff     <= dz_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      result_ff <= result_in;
   end

   assign sts    = '{done: done_ff, dz: dz_ff};
   assign result = result_ff;

endmodule

### design/infix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator core
// Takes an expression one character per transfer (digits, spaces, + - * /,
// tlast on the final character) and returns one 32-bit result per expression,
// with precedence of * and / over + and -, truncating division, and wrapping
// at DATA_WIDTH bits; tuser flags a division by zero. After a digit or a space
// that is not the final character the input stays ready. An operator, or the
// end, that closes a * or / operand runs the shared shift-add/restoring
// multiply-divide unit one bit per cycle (with a zero divisor the unit skips
// the bit loop), and a final character may close two such operands; any
// other operator does not use the unit.
// The input is not ready while a character is being worked on. The result
// waits in an output register, and the next expression may start meanwhile.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_core #(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [0:0]  rsp_tuser    // [0] div_by_zero
);

   localparam int DW = DATA_WIDTH;
   localparam int VW = iee_pkg::VALUE_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FIN  = 4'b0010,
      S_WAIT = 4'b0100,
      S_POST = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [DW-1:0]      accum_ff, accum_in;
   logic [DW-1:0]      term_ff, term_in;
   logic [DW-1:0]      number_ff, number_in;
   logic               sign_ff, sign_in;
   iee_pkg::pend_type  pend_ff, pend_in;
   logic               error_ff, error_in;
   logic [7:0]         ch_ff, ch_in;
   logic               op_ff, op_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]      rsp_data_ff, rsp_data_in;
   logic               rsp_dz_ff, rsp_dz_in;

   iee_pkg::mdu_req_type mdu_req;
   iee_pkg::mdu_sts_type mdu_sts;
   logic [DW-1:0]        mdu_result;

   logic               accept;
   logic               is_digit;
   logic               is_space;
   logic [3:0]         digit;
   logic [7:0]         ch_off;
   logic [DW-1:0]      commit_val;
   logic [DW+VW-1:0]   value_ext;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_digit   = (req_tdata >= iee_pkg::CHAR_ZERO) && (req_tdata <= iee_pkg::CHAR_NINE);
   assign is_space   = (req_tdata == iee_pkg::CHAR_SPACE);
   assign ch_off     = req_tdata - iee_pkg::CHAR_ZERO;
   assign digit      = ch_off[3:0];
   assign commit_val = sign_ff ? (accum_ff - term_ff) : (accum_ff + term_ff);
   assign value_ext  = {{VW{1'b0}}, commit_val};

   assign mdu_req.start = (state_ff == S_FIN) && (pend_ff != iee_pkg::PEND_NONE);
   assign mdu_req.op    = (pend_ff == iee_pkg::PEND_DIV) ? iee_pkg::OP_DIV : iee_pkg::OP_MUL;

   iee_muldiv #(
      .DATA_WIDTH (DW)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .req    (mdu_req),
      .opa    (term_ff),
      .opb    (number_ff),
      .sts    (mdu_sts),
      .result (mdu_result)
   );

   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      term_in      = term_ff;
      number_in    = number_ff;
      sign_in      = sign_ff;
      pend_in      = pend_ff;
      error_in     = error_ff;
      ch_in        = ch_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_dz_in    = rsp_dz_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ch_in   = req_tdata;
               last_in = req_tlast;
               op_in   = !is_digit && !is_space;
               if (is_digit) begin
                  number_in = (number_ff << 3) + (number_ff << 1)
                            + {{(DW-4){1'b0}}, digit};
               end
               if (req_tlast || op_in) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (pend_ff == iee_pkg::PEND_NONE) begin
               term_in   = number_ff;
               number_in = '0;
               state_in  = S_POST;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mdu_sts.done) begin
               term_in   = mdu_result;
               error_in  = error_ff || mdu_sts.dz;
               pend_in   = iee_pkg::PEND_NONE;
               number_in = '0;
               state_in  = S_POST;
            end
         end
         S_POST: begin
            if (op_ff) begin
               op_in = 1'b0;
               if (ch_ff == iee_pkg::CHAR_STAR) begin
                  pend_in = iee_pkg::PEND_MUL;
               end else if (ch_ff == iee_pkg::CHAR_SLASH) begin
                  pend_in = iee_pkg::PEND_DIV;
               end else begin
                  accum_in = commit_val;
                  term_in  = '0;
                  sign_in  = (ch_ff != iee_pkg::CHAR_PLUS);
               end
               state_in = last_ff ? S_FIN : S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = value_ext[VW-1:0];
               rsp_dz_in    = error_ff;
               accum_in     = '0;
               term_in      = '0;
               number_in    = '0;
               sign_in      = 1'b0;
               pend_in      = iee_pkg::PEND_NONE;
               error_in     = 1'b0;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         accum_ff     <= '0;
         term_ff      <= '0;
         number_ff    <= '0;
         sign_ff      <= 1'b0;
         pend_ff      <= iee_pkg::PEND_NONE;
         error_ff     <= 1'b0;
         op_ff        <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         term_ff      <= term_in;
         number_ff    <= number_in;
         sign_ff      <= sign_in;
         pend_ff      <= pend_in;
         error_ff     <= error_in;
         op_ff        <= op_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      rsp_data_ff <= rsp_data_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_dz_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mdu_sts.done |-> state_ff == S_WAIT)
      else $error("muldiv completion outside wait state");

   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_POST))
      else $error("result loaded outside post state");

   a_start_pending: assert property (@(posedge clock) disable iff (reset)
      mdu_req.start |=> state_ff == S_WAIT)
      else $error("muldiv start without wait");

endmodule
